/* hw/rtl/gnss_mode_search_selector_core_assert.svh */
// assertion macros for the checker of the mode search selector
`ifndef GNSS_MODE_SEARCH_SELECTOR_CORE_ASSERT_SVH
`define GNSS_MODE_SEARCH_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GMSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmss assertion failed");

// next-cycle implication, disabled during reset
`define GMSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmss assertion failed");

`endif

/* hw/rtl/gmss_pkg.sv */
package gmss_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_FIX    = 2'd1;
  localparam logic [1:0] ACT_MANUAL = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODES_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PDOP_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY     = 3'd5;

  // fixed constants of the selector
  localparam logic [7:0]  INVALID_RUN_LIMIT = 8'd200;
  localparam logic [3:0]  BEST_MODE_RESET   = 4'd7;
  localparam logic [15:0] BEST_PDOP_RESET   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic        fix_valid;
    logic [15:0] pdop_hundredths;
    logic [3:0]  manual_mode;
    logic [3:0]  manual_search_mode;
  } in_t;

  typedef struct packed {
    logic        apply_strobe;
    logic [3:0]  applied_mode;
    logic [3:0]  current_mode;
    logic [3:0]  search_position;
    logic        search_done;
    logic [3:0]  found_mode;
    logic [15:0] found_pdop;
  } out_t;

  typedef struct packed {
    logic [3:0]  modes_count;
    logic [15:0] dwell_ticks;
    logic [15:0] pdop_limit;
    logic [7:0]  bad_limit;
    logic [3:0]  search_start_mode;
    logic        standby;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode_now;
    logic [3:0]  srch_pos;
    logic [15:0] dwell_cnt;
    logic [3:0]  best_mode;
    logic [15:0] best_pdop;
    logic [7:0]  bad_cnt;
    logic [7:0]  inval_cnt;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    modes_count:       4'd7,
    dwell_ticks:       16'd240,
    pdop_limit:        16'd400,
    bad_limit:         8'd60,
    search_start_mode: 4'd7,
    standby:           1'b0
  };

  localparam state_t STATE_RESET = '{
    mode_now:  4'd7,
    srch_pos:  4'd7,
    dwell_cnt: 16'd0,
    best_mode: BEST_MODE_RESET,
    best_pdop: BEST_PDOP_RESET,
    bad_cnt:   8'd0,
    inval_cnt: 8'd0
  };

endpackage

/* hw/rtl/gmss_cfg.sv */
module gmss_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gmss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmss_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gmss_pkg::cfg_t                   cfg
);

  gmss_pkg::cfg_t cfg_r;

  // register file, writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= gmss_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gmss_pkg::REG_MODES_COUNT: cfg_r.modes_count       <= cfg_data[3:0];
        gmss_pkg::REG_DWELL_TICKS: cfg_r.dwell_ticks       <= cfg_data;
        gmss_pkg::REG_PDOP_LIMIT:  cfg_r.pdop_limit        <= cfg_data;
        gmss_pkg::REG_BAD_LIMIT:   cfg_r.bad_limit         <= cfg_data[7:0];
        gmss_pkg::REG_START_MODE:  cfg_r.search_start_mode <= cfg_data[3:0];
        gmss_pkg::REG_STANDBY:     cfg_r.standby           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/gmss_step.sv */
module gmss_step (
  input  gmss_pkg::state_t st,
  input  gmss_pkg::cfg_t   cfg,
  input  gmss_pkg::in_t    item,
  output gmss_pkg::state_t st_nxt,
  output gmss_pkg::out_t   res
);

  always_comb begin
    logic [15:0] dwell_inc;
    logic [4:0]  pos_inc;
    logic [7:0]  bad_inc;
    logic        p_nz;

    st_nxt    = st;
    res       = '0;
    dwell_inc = st.dwell_cnt + 16'd1;
    pos_inc   = {1'b0, st.srch_pos} + 5'd1;
    bad_inc   = st.bad_cnt + 8'd1;
    p_nz      = (item.pdop_hundredths != 16'd0);

    unique case (item.action)
      // report tick: dwell on the current position, advance, finish
      gmss_pkg::ACT_TICK: begin
        if (!cfg.standby && (st.srch_pos != 4'd0)) begin
          if (st.dwell_cnt == 16'd0) begin
            res.apply_strobe = 1'b1;
            res.applied_mode = st.srch_pos;
            st_nxt.mode_now  = st.srch_pos;
          end
          st_nxt.dwell_cnt = dwell_inc;
          if (dwell_inc > cfg.dwell_ticks) begin
            st_nxt.dwell_cnt = 16'd0;
            if (pos_inc > {1'b0, cfg.modes_count}) begin
              st_nxt.srch_pos  = 4'd0;
              res.apply_strobe = 1'b1;
              res.applied_mode = st.best_mode;
              st_nxt.mode_now  = st.best_mode;
              res.search_done  = 1'b1;
              res.found_mode   = st.best_mode;
              res.found_pdop   = st.best_pdop;
              st_nxt.best_mode = gmss_pkg::BEST_MODE_RESET;
              st_nxt.best_pdop = gmss_pkg::BEST_PDOP_RESET;
            end else begin
              st_nxt.srch_pos = pos_inc[3:0];
            end
          end
        end
      end
      // fix report: track best pdop, count bad and invalid fixes
      gmss_pkg::ACT_FIX: begin
        if (item.fix_valid) begin
          if (p_nz && (item.pdop_hundredths < st.best_pdop) && (st.srch_pos != 4'd0)) begin
            st_nxt.best_pdop = item.pdop_hundredths;
            st_nxt.best_mode = st.srch_pos;
          end
          if (p_nz && (item.pdop_hundredths < cfg.pdop_limit)) begin
            st_nxt.bad_cnt = 8'd0;
          end
          if ((!p_nz || (item.pdop_hundredths > cfg.pdop_limit)) && (st.srch_pos == 4'd0)) begin
            if (bad_inc > cfg.bad_limit) begin
              st_nxt.bad_cnt  = 8'd0;
              st_nxt.srch_pos = cfg.search_start_mode;
            end else begin
              st_nxt.bad_cnt = bad_inc;
            end
          end
        end else begin
          if (st.inval_cnt < gmss_pkg::INVALID_RUN_LIMIT) begin
            st_nxt.inval_cnt = st.inval_cnt + 8'd1;
          end else begin
            st_nxt.inval_cnt = 8'd0;
            st_nxt.srch_pos  = cfg.search_start_mode;
          end
        end
      end
      // manual override, no apply
      gmss_pkg::ACT_MANUAL: begin
        st_nxt.mode_now = item.manual_mode;
        st_nxt.srch_pos = (item.manual_search_mode <= cfg.modes_count) ?
                          item.manual_search_mode : 4'd0;
      end
      default: ;
    endcase

    res.current_mode    = st_nxt.mode_now;
    res.search_position = st_nxt.srch_pos;
  end

endmodule

/* hw/rtl/gnss_mode_search_selector_core.sv */
// GNSS constellation mode selector driven by PDOP. One input item (report tick,
// fix report or manual override) is accepted per clock unless out_ready stalls a
// full result register; each gives exactly one result item, held in the input
// register, then in the result register. The throughput of one item per cycle is
// set by the selector state, read and rewritten in the same cycle by one compare and
// increment step. The user writes configuration via cfg_we, cfg_index and cfg_data
// only while no item is in flight, not enforced; indexes above five are ignored.
module gnss_mode_search_selector_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  gmss_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output gmss_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [gmss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  gmss_pkg::cfg_t   cfg;
  gmss_pkg::state_t st_r;
  gmss_pkg::state_t st_nxt;
  gmss_pkg::in_t    in_data_r;
  gmss_pkg::out_t   res;
  gmss_pkg::out_t   out_data_r;
  logic             in_v_r;
  logic             out_v_r;
  logic             slot_free;
  logic             advance;

  // configuration registers
  gmss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // one selector step per item
  gmss_step u_step (
    .st     (st_r),
    .cfg    (cfg),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // flow control between input and result registers
  assign slot_free = !out_v_r || out_ready;
  assign advance   = in_v_r && slot_free;
  assign in_ready  = !in_v_r || slot_free;

  // valid flags and selector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= gmss_pkg::STATE_RESET;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (slot_free) begin
        out_v_r <= in_v_r;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/gmss_checker.sv */
`include "gnss_mode_search_selector_core_assert.svh"

module gmss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input gmss_pkg::out_t                   out_data
);

  logic done_ok;
  logic found_clear;
  logic cur_match;
  logic applied_clear;

  // result field relations
  assign done_ok       = out_data.apply_strobe &&
                         (out_data.applied_mode == out_data.found_mode) &&
                         (out_data.search_position == 4'd0);
  assign found_clear   = (out_data.found_mode == 4'd0) && (out_data.found_pdop == 16'd0);
  assign cur_match     = (out_data.current_mode == out_data.applied_mode);
  assign applied_clear = (out_data.applied_mode == 4'd0);

  // a stalled result holds
  `GMSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a finished search applies the found mode and leaves the search
  `GMSS_ASSERT_IMP(a_done_apply, clk, rst_n, out_valid && out_data.search_done, done_ok)

  // found fields are zero outside a search end
  `GMSS_ASSERT_IMP(a_found_zero, clk, rst_n, out_valid && !out_data.search_done, found_clear)

  // an applied mode becomes the current mode, no apply shows mode zero
  `GMSS_ASSERT_IMP(a_apply_cur, clk, rst_n, out_valid && out_data.apply_strobe, cur_match)
  `GMSS_ASSERT_IMP(a_noapply_zero, clk, rst_n, out_valid && !out_data.apply_strobe, applied_clear)

endmodule

bind gnss_mode_search_selector_core gmss_checker u_gmss_checker (.*);
